### rtl/ktp_pkg.sv
// shared types, constants and the uniform-pattern table for the kirsch ternary pattern block
`timescale 1ns / 1ps
`default_nettype none

package ktp_pkg;

    localparam int RING_SIZE = 8;
    localparam logic [15:0] THRESHOLD_RESET = 16'd70;
    localparam logic [5:0] NONUNIFORM_BIN = 6'd58;

    typedef struct packed {
        logic [15:0] pix_nw;
        logic [15:0] pix_n;
        logic [15:0] pix_ne;
        logic [15:0] pix_w;
        logic [15:0] pix_e;
        logic [15:0] pix_sw;
        logic [15:0] pix_s;
        logic [15:0] pix_se;
    } pix_item_t;

    typedef struct packed {
        logic [7:0] pos_pattern;
        logic [7:0] neg_pattern;
        logic [5:0] pos_uniform;
        logic [5:0] neg_uniform;
    } code_item_t;

    typedef logic [5:0] bin_lut_t [256];

    // at most two transitions when read circularly
    function automatic logic is_uniform(input logic [7:0] code);
        logic [7:0] diff;
        int         n;
        diff = code ^ {code[6:0], code[7]};
        n = 0;
        for (int b = 0; b < 8; b++)
        begin
            n += int'(diff[b]);
        end
        return (n <= 2);
    endfunction

    function automatic bin_lut_t build_uniform_lut();
        bin_lut_t lut;
        int       rank;
        rank = 0;
        for (int c = 0; c < 256; c++)
        begin
            if (is_uniform(8'(c)))
            begin
                lut[c] = 6'(rank);
                rank++;
            end
            else
            begin
                lut[c] = NONUNIFORM_BIN;
            end
        end
        return lut;
    endfunction

    localparam bin_lut_t UNIFORM_LUT = build_uniform_lut();

endpackage

`default_nettype wire

### rtl/ktp_resp.sv
// window sums and the eight compass responses, two pipeline stages
`timescale 1ns / 1ps
`default_nettype none

module ktp_resp #(
    parameter int PIXEL_BITS = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  pix_valid,
    output logic                                       pix_stall,
    input  wire ktp_pkg::pix_item_t                    pix,
    output logic                                       resp_valid,
    input  wire logic                                  resp_ready,
    output logic [ktp_pkg::RING_SIZE-1:0][PIXEL_BITS+5:0] resp
);

    localparam int SW = PIXEL_BITS + 2;
    localparam int TW = PIXEL_BITS + 3;
    localparam int RW = PIXEL_BITS + 6;
    localparam int RN = ktp_pkg::RING_SIZE;

    logic [RN-1:0][PIXEL_BITS-1:0] ring;
    logic [RN-1:0][SW-1:0]         sum3_next;
    logic [RN-1:0][SW-1:0]         sum3_reg;
    logic [TW-1:0]                 total_next;
    logic [TW-1:0]                 total_reg;
    logic [RN-1:0][RW-1:0]         resp_next;
    logic [RN-1:0][RW-1:0]         resp_reg;
    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic                          s2_valid_reg;
    logic                          s2_valid_next;
    logic                          s1_en;
    logic                          s2_en;

    // neighbours in clockwise order from the top-left corner
    assign ring[0] = pix.pix_nw[PIXEL_BITS-1:0];
    assign ring[1] = pix.pix_n[PIXEL_BITS-1:0];
    assign ring[2] = pix.pix_ne[PIXEL_BITS-1:0];
    assign ring[3] = pix.pix_e[PIXEL_BITS-1:0];
    assign ring[4] = pix.pix_se[PIXEL_BITS-1:0];
    assign ring[5] = pix.pix_s[PIXEL_BITS-1:0];
    assign ring[6] = pix.pix_sw[PIXEL_BITS-1:0];
    assign ring[7] = pix.pix_w[PIXEL_BITS-1:0];

    assign s2_en     = !s2_valid_reg || resp_ready;
    assign s1_en     = !s1_valid_reg || s2_en;
    assign pix_stall = !s1_en;

    // mask i weights by 5 the three neighbours at ring positions 2-i, 3-i and 4-i, modulo 8
    for (genvar i = 0; i < RN; i++)
    begin : g_sum3
        assign sum3_next[i] = SW'(ring[(RN + 2 - i) % RN])
                            + SW'(ring[(RN + 3 - i) % RN])
                            + SW'(ring[(RN + 4 - i) % RN]);
    end

    assign total_next = (TW'(ring[0]) + TW'(ring[1])) + (TW'(ring[2]) + TW'(ring[3]))
                      + (TW'(ring[4]) + TW'(ring[5])) + (TW'(ring[6]) + TW'(ring[7]));

    // 5*s - 3*(total - s) = 8*s - 3*total
    for (genvar i = 0; i < RN; i++)
    begin : g_resp
        assign resp_next[i] = RW'({sum3_reg[i], 3'b000})
                            - (RW'(total_reg) + RW'({total_reg, 1'b0}));
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s2_valid_next = s2_valid_reg;
        if (s1_en)
        begin
            s1_valid_next = pix_valid;
        end
        if (s2_en)
        begin
            s2_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            sum3_reg  <= sum3_next;
            total_reg <= total_next;
        end
        if (s2_en)
        begin
            resp_reg <= resp_next;
        end
    end

    assign resp_valid = s2_valid_reg;
    assign resp       = resp_reg;

endmodule

`default_nettype wire

### rtl/ktp_code.sv
// threshold compares into ternary codes and uniform-bin lookup, two pipeline stages
`timescale 1ns / 1ps
`default_nettype none

module ktp_code #(
    parameter int PIXEL_BITS = 16
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     resp_valid,
    output logic                                          resp_ready,
    input  wire logic [ktp_pkg::RING_SIZE-1:0][PIXEL_BITS+5:0] resp,
    input  wire logic [15:0]                              threshold,
    output logic                                          code_valid,
    input  wire logic                                     code_stall,
    output ktp_pkg::code_item_t                           code
);

    localparam int RW = PIXEL_BITS + 6;
    localparam int CW = (RW > 18) ? RW : 18;
    localparam int RN = ktp_pkg::RING_SIZE;

    logic signed [CW-1:0] thr_pos;
    logic signed [CW-1:0] thr_neg;
    logic [7:0]           pos_next;
    logic [7:0]           neg_next;
    logic [7:0]           pos_reg;
    logic [7:0]           neg_reg;
    ktp_pkg::code_item_t  code_next;
    ktp_pkg::code_item_t  code_reg;
    logic                 s3_valid_reg;
    logic                 s3_valid_next;
    logic                 s4_valid_reg;
    logic                 s4_valid_next;
    logic                 s3_en;
    logic                 s4_en;

    assign s4_en      = !s4_valid_reg || !code_stall;
    assign s3_en      = !s3_valid_reg || s4_en;
    assign resp_ready = s3_en;

    assign thr_pos = $signed({{(CW-16){1'b0}}, threshold});
    assign thr_neg = -thr_pos;

    for (genvar i = 0; i < RN; i++)
    begin : g_cmp
        logic signed [CW-1:0] r_ext;
        assign r_ext           = CW'($signed(resp[i]));
        assign pos_next[7 - i] = (r_ext >= thr_pos);
        assign neg_next[7 - i] = (r_ext <= thr_neg);
    end

    always_comb
    begin
        code_next.pos_pattern = pos_reg;
        code_next.neg_pattern = neg_reg;
        code_next.pos_uniform = ktp_pkg::UNIFORM_LUT[pos_reg];
        code_next.neg_uniform = ktp_pkg::UNIFORM_LUT[neg_reg];
    end

    always_comb
    begin
        s3_valid_next = s3_valid_reg;
        s4_valid_next = s4_valid_reg;
        if (s3_en)
        begin
            s3_valid_next = resp_valid;
        end
        if (s4_en)
        begin
            s4_valid_next = s3_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s3_valid_next;
            s4_valid_reg <= s4_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_en)
        begin
            pos_reg <= pos_next;
            neg_reg <= neg_next;
        end
        if (s4_en)
        begin
            code_reg <= code_next;
        end
    end

    assign code_valid = s4_valid_reg;
    assign code       = code_reg;

endmodule

`default_nettype wire

### rtl/kirsch_ternary_pattern_codes.sv
// top level of the kirsch ternary pattern code block
// four register stages lie between an accepted request and its result in the output register
// throughput: one request per cycle while code_stall is low, via per-stage valid bits
// a stalled output holds its result while earlier stages keep filling any bubbles
// reset: asynchronous active low, empties the pipeline and sets the threshold to 70
`timescale 1ns / 1ps
`default_nettype none

module kirsch_ternary_pattern_codes #(
    parameter int PIXEL_BITS = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [15:0]         cfg_data,
    input  wire logic                pix_valid,
    output logic                     pix_stall,
    input  wire ktp_pkg::pix_item_t  pix,
    output logic                     code_valid,
    input  wire logic                code_stall,
    output ktp_pkg::code_item_t      code
);

    logic [15:0]                                    threshold_reg;
    logic [15:0]                                    threshold_next;
    logic                                           resp_valid;
    logic                                           resp_ready;
    logic [ktp_pkg::RING_SIZE-1:0][PIXEL_BITS+5:0]  resp;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        threshold_next = threshold_reg;
        if (cfg_valid && cfg_ready)
        begin
            threshold_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= ktp_pkg::THRESHOLD_RESET;
        end
        else
        begin
            threshold_reg <= threshold_next;
        end
    end

    ktp_resp #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_resp (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (pix_valid),
        .pix_stall  (pix_stall),
        .pix        (pix),
        .resp_valid (resp_valid),
        .resp_ready (resp_ready),
        .resp       (resp)
    );

    ktp_code #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_code (
        .clk        (clk),
        .rst_n      (rst_n),
        .resp_valid (resp_valid),
        .resp_ready (resp_ready),
        .resp       (resp),
        .threshold  (threshold_reg),
        .code_valid (code_valid),
        .code_stall (code_stall),
        .code       (code)
    );

endmodule

`default_nettype wire
